/* hw/rtl/scw_pkg.sv */
// ----------------------------------------------------------------------------
// scw_pkg: shared types and constants of the soft clip waveshaper
// Register indexes, reset values, fixed-point shifts and the status groups
// passed between the sequencer, the serial multiplier and the top level.
// ----------------------------------------------------------------------------
package scw_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PASS_W    = 8;
  localparam int MIX_W     = 16;
  localparam int GAIN_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_AMOUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 2'd2;

  localparam logic [PASS_W-1:0] PASS_RESET = 8'd1;
  localparam logic [MIX_W-1:0]  MIX_RESET  = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  localparam logic [MIX_W-1:0] MIX_ONE = 16'h8000;

  localparam int MIX_FRAC  = 15;
  localparam int GAIN_FRAC = 12;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } shp_stat_t;

endpackage

/* hw/rtl/scw_if.sv */
// ----------------------------------------------------------------------------
// scw_if: word channels of the soft clip waveshaper
// Valid/ready channels for input samples and shaped result samples.
// ----------------------------------------------------------------------------
interface scw_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface scw_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

/* hw/rtl/scw_serial_mult.sv */
// ----------------------------------------------------------------------------
// scw_serial_mult: bit-serial shift-add multiplier
// Signed AW-bit operand times unsigned BW-bit operand, one multiplier bit per
// cycle through a right-shifting product register.
// ----------------------------------------------------------------------------
module scw_serial_mult #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AW-1:0]    op_a,
  input  logic [BW-1:0]           op_b,
  output logic signed [AW+BW-1:0] prod,
  output scw_pkg::mul_stat_t      stat
);
  import scw_pkg::*;

  localparam int CW = $clog2(BW);

  logic signed [AW-1:0] hi_r;
  logic [BW-1:0]        lo_r;
  logic signed [AW-1:0] a_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic signed [AW:0]   sum;

  assign sum = {hi_r[AW-1], hi_r} + (lo_r[0] ? {a_r[AW-1], a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        hi_r   <= '0;
        lo_r   <= op_b;
        a_r    <= op_a;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        hi_r  <= sum[AW:1];
        lo_r  <= {sum[0], lo_r[BW-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod      = $signed({hi_r, lo_r});
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier restarted while busy");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("product flagged without a run");

endmodule

/* hw/rtl/scw_shaper.sv */
// ----------------------------------------------------------------------------
// scw_shaper: pass sequencer of the soft clip waveshaper
// Steps square, blend and gain products through one serial multiplier,
// repeats the pass per sample and saturates the gained result.
// ----------------------------------------------------------------------------
module scw_shaper #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic [scw_pkg::PASS_W-1:0]     pass_count,
  input  logic [scw_pkg::MIX_W-1:0]      mix_sat,
  input  logic [scw_pkg::GAIN_W-1:0]     gain,
  input  logic                           take,
  output scw_pkg::shp_stat_t             stat,
  output logic signed [SAMPLE_WIDTH-1:0] res
);
  import scw_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int AW = W + 1;
  localparam int BW = (W > 16) ? W : 16;
  localparam int PW = AW + BW;
  localparam int GV = PW - GAIN_FRAC;

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_SQ, S_MIXX, S_MIXS, S_GAIN, S_DONE
  } state_t;

  state_t               state_r;
  logic signed [AW-1:0] x_r;
  logic [W-1:0]         a_r;
  logic                 neg_r;
  logic signed [AW-1:0] s_r;
  logic signed [PW-1:0] acc_r;
  logic [PASS_W-1:0]    cnt_r;
  logic signed [W-1:0]  res_r;
  logic                 mul_start_r;
  logic signed [AW-1:0] mul_a_r;
  logic [BW-1:0]        mul_b_r;

  logic signed [PW-1:0] prod;
  mul_stat_t            mstat;

  logic signed [AW-1:0] x_abs;
  logic [AW-1:0]        sq_sh;
  logic [AW-1:0]        s_mag;
  logic signed [AW-1:0] s_sgn;
  logic signed [PW:0]   blend_full;
  logic signed [AW-1:0] blend;
  logic [MIX_W-1:0]     mix_comp;
  logic [GV-1:0]        gv;
  logic [GV-W:0]        gtop;
  logic                 gfits;
  logic signed [W-1:0]  clamped;

  scw_serial_mult #(
    .AW(AW),
    .BW(BW)
  ) u_mult (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start_r),
    .op_a (mul_a_r),
    .op_b (mul_b_r),
    .prod (prod),
    .stat (mstat)
  );

  assign x_abs      = x_r[AW-1] ? -x_r : x_r;
  assign sq_sh      = prod[W-1 +: AW];
  assign s_mag      = {a_r, 1'b0} - sq_sh;
  assign s_sgn      = neg_r ? -$signed(s_mag) : $signed(s_mag);
  assign blend_full = {acc_r[PW-1], acc_r} + {prod[PW-1], prod};
  assign blend      = blend_full[MIX_FRAC +: AW];
  assign mix_comp   = MIX_ONE - mix_sat;
  assign gv         = prod[PW-1:GAIN_FRAC];
  assign gtop       = gv[GV-1:W-1];
  assign gfits      = (gtop == '0) || (&gtop);
  assign clamped    = gfits ? $signed(gv[W-1:0]) :
                      gv[GV-1] ? $signed({1'b1, {(W-1){1'b0}}}) :
                                 $signed({1'b0, {(W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (pass_count == '0) begin
              res_r   <= sample_in;
              state_r <= S_DONE;
            end else begin
              x_r     <= AW'(sample_in);
              cnt_r   <= pass_count;
              state_r <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          a_r         <= x_abs[W-1:0];
          neg_r       <= x_r[AW-1];
          mul_a_r     <= {1'b0, x_abs[W-1:0]};
          mul_b_r     <= BW'(x_abs[W-1:0]);
          mul_start_r <= 1'b1;
          state_r     <= S_SQ;
        end
        S_SQ: begin
          if (mstat.done) begin
            s_r         <= s_sgn;
            mul_a_r     <= x_r;
            mul_b_r     <= BW'(mix_comp);
            mul_start_r <= 1'b1;
            state_r     <= S_MIXX;
          end
        end
        S_MIXX: begin
          if (mstat.done) begin
            acc_r       <= prod;
            mul_a_r     <= s_r;
            mul_b_r     <= BW'(mix_sat);
            mul_start_r <= 1'b1;
            state_r     <= S_MIXS;
          end
        end
        S_MIXS: begin
          if (mstat.done) begin
            x_r   <= blend;
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == PASS_W'(1)) begin
              mul_a_r     <= blend;
              mul_b_r     <= BW'(gain);
              mul_start_r <= 1'b1;
              state_r     <= S_GAIN;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        S_GAIN: begin
          if (mstat.done) begin
            res_r   <= clamped;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res            = res_r;

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (start && stat.idle && (pass_count == '0)) |=> stat.res_valid)
    else $error("zero-pass sample not bypassed");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.res_valid && !take) |=> (stat.res_valid && $stable(res)))
    else $error("result lost before hand-over");

endmodule

/* hw/rtl/soft_clip_waveshaper.sv */
// ----------------------------------------------------------------------------
// soft_clip_waveshaper: soft clipping waveshaper top level
// Shapes each sample by repeated 2|x| - x*x passes blended with the pass
// input, applies output gain and saturates; one serial multiplier does it all.
//
//   channel   direction  handshake     word
//   in_word   in         valid/ready   sample_in  (SAMPLE_WIDTH, signed)
//   out_word  out        valid/ready   sample_out (SAMPLE_WIDTH, signed)
//   cfg_*     in         write enable  cfg_idx 2 bits, cfg_wdata 16 bits
//
// One sample at a time; each product runs on the shift-add multiplier with
// B = max(SAMPLE_WIDTH, 16) multiplier bits. One pass takes a square and two
// blend products; after the last pass come the gain product and the hand-over
// to the output register. A pass_count of zero returns the word unchanged.
// Reset clears the control state and loads the register defaults.
// The output register holds a result while out_word stalls; the next word is
// taken as soon as the sequencer is idle, whatever the output side does.
// ----------------------------------------------------------------------------
module soft_clip_waveshaper #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [scw_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [scw_pkg::CFG_W-1:0]         cfg_wdata,
  scw_in_if.sink                            in_word,
  scw_out_if.source                         out_word
);
  import scw_pkg::*;

  logic [PASS_W-1:0]             pass_r;
  logic [MIX_W-1:0]              mix_r;
  logic [GAIN_W-1:0]             gain_r;
  logic [MIX_W-1:0]              mix_sat;
  logic                          out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  shp_stat_t                     shp_stat;
  logic signed [SAMPLE_WIDTH-1:0] shp_res;
  logic                          in_acc;
  logic                          take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= PASS_RESET;
      mix_r  <= MIX_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PASS_COUNT:  pass_r <= cfg_wdata[PASS_W-1:0];
        CFG_MIX_AMOUNT:  mix_r  <= cfg_wdata[MIX_W-1:0];
        CFG_OUTPUT_GAIN: gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign mix_sat       = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;
  assign in_word.ready = shp_stat.idle;
  assign in_acc        = in_word.valid && in_word.ready;
  assign take          = shp_stat.res_valid && (!out_valid_r || out_word.ready);

  scw_shaper #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_shaper (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .sample_in (in_word.sample_in),
    .pass_count(pass_r),
    .mix_sat   (mix_sat),
    .gain      (gain_r),
    .take      (take),
    .stat      (shp_stat),
    .res       (shp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= shp_res;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.sample_out = out_sample_r;

  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(shp_stat.res_valid))
    else $error("output word raised without a result");

endmodule
